[rtl/core/ppsd_pkg.sv]
// ----------------------------------------------------------------------------
// ppsd_pkg: shared types and constants
// Limit width, configuration register codes and sequencer states for the
// point-to-polyline squared distance block.
// ----------------------------------------------------------------------------
package ppsd_pkg;

  localparam int LIMIT_BITS   = 49;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUERY_X    = 2'd0,
    CFG_QUERY_Y    = 2'd1,
    CFG_NEAR_LIMIT = 2'd2,
    CFG_FAR_LIMIT  = 2'd3
  } ppsd_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_DECIDE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_SCORE,
    ST_FINISH
  } ppsd_state_e;

endpackage

[rtl/core/ppsd_vertex_if.sv]
// ----------------------------------------------------------------------------
// ppsd_vertex_if: vertex channel
// Valid/ready channel carrying one polyline vertex per item.
// ----------------------------------------------------------------------------
interface ppsd_vertex_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

[rtl/core/ppsd_result_if.sv]
// ----------------------------------------------------------------------------
// ppsd_result_if: result channel
// Valid/ready channel carrying the squared distance of one polyline.
// ----------------------------------------------------------------------------
interface ppsd_result_if;
  import ppsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] squared_distance;
  logic                  close_hit;

  modport source (output valid, output squared_distance, output close_hit, input ready);
  modport sink   (input valid, input squared_distance, input close_hit, output ready);
endinterface

[rtl/core/ppsd_ser_mul.sv]
// ----------------------------------------------------------------------------
// ppsd_ser_mul: digit-serial unsigned multiplier
// Radix-4 shift-add multiplier; consumes two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module ppsd_ser_mul #(
  parameter int W = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           busy_o,
  output logic [2*W-1:0] product_o
);
  localparam int D  = (W + 1) / 2;
  localparam int PW = W + 2 + 2 * D;
  localparam int CW = $clog2(D + 1);

  logic [CW-1:0] cnt_q;
  logic [W-1:0]  mcand_q;
  logic [PW-1:0] p_q, p_d;
  logic [W+1:0]  pp, hi_sum;

  // partial product for the current radix-4 digit
  always_comb begin
    pp     = ({2'b00, mcand_q} & {(W+2){p_q[0]}})
           + ({1'b0, mcand_q, 1'b0} & {(W+2){p_q[1]}});
    hi_sum = p_q[PW-1:2*D] + pp;
    p_d    = {2'b00, hi_sum, p_q[2*D-1:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(D);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      p_q     <= PW'(b_i);
    end else if (cnt_q != '0) begin
      p_q <= p_d;
    end
  end

  assign busy_o    = (cnt_q != '0);
  assign product_o = p_q[2*W-1:0];

endmodule

[rtl/core/ppsd_ser_div.sv]
// ----------------------------------------------------------------------------
// ppsd_ser_div: bit-serial restoring divider
// Divides a 2N-bit dividend by an N-bit divisor, one quotient bit per cycle;
// the upper half of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module ppsd_ser_div #(
  parameter int N = 51
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*N-1:0] dividend_i,
  input  logic [N-1:0]   divisor_i,
  output logic           busy_o,
  output logic [N-1:0]   quotient_o
);
  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt_q;
  logic [N-1:0]  rem_q, quo_q, dvs_q;
  logic [N:0]    trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[N-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(N);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // low half of the dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*N-1:N];
      quo_q <= dividend_i[N-1:0];
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[N-1:0] : trial[N-1:0];
      quo_q <= {quo_q[N-2:0], ge};
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

[rtl/core/point_polyline_squared_distance_top.sv]
// ----------------------------------------------------------------------------
// point_polyline_squared_distance_top: squared distance from point to polyline
// Sequencing: an accepted vertex runs the product lanes (ST_PROD), then ST_SUM and
//   ST_DECIDE. A vertex that seeds or is skipped goes on to ST_FINISH, one scored
//   by its end vertex distance to ST_SCORE, and a foot point runs the serial
//   squaring unit (ST_SQUARE) and the serial divider (ST_DIVIDE) before ST_SCORE;
//   a last vertex loads a result item in ST_FINISH. The next vertex is taken only
//   back in ST_IDLE. Reset restores the configuration registers and control state.
// ----------------------------------------------------------------------------
// Streams the vertices of one polyline and reports the smallest squared
// distance from the configured query point, clamped to the far limit. A
// new minimum at or below the near limit ends the search early: the near
// limit goes out with close_hit set; the rest of the polyline is dropped.
//
// Datapath per vertex:
//   - on accept, form u = P - query, v = Q - P, d = Q - query and start eight
//     radix-4 serial multipliers (squares and the two dot product terms)
//   - add up |u|^2, |v|^2, |d|^2 and s = -(u.v)
//   - decide: seed the minimum (first vertex), skip, take |d|^2, or square s
//     serially and divide s^2 by |v|^2 bit-serially for the foot point
//   - compare the score with the minimum and the near limit
// A result item waits in an output register, so the next vertex is taken
// while it is still pending; only a second last vertex stalls behind it.
// ----------------------------------------------------------------------------
module point_polyline_squared_distance_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ppsd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [ppsd_pkg::LIMIT_BITS-1:0]      cfg_wdata_i,
  ppsd_vertex_if.sink                          vertex_i,
  ppsd_result_if.source                        result_o
);
  import ppsd_pkg::*;

  localparam int MagBits = COORD_BITS + 1;
  localparam int SumBits = 2 * MagBits + 1;
  localparam int CmpBits = (SumBits > LIMIT_BITS) ? SumBits : LIMIT_BITS;
  localparam int Lanes   = 8;

  // product lanes
  localparam int LnUx2 = 0;
  localparam int LnUy2 = 1;
  localparam int LnVx2 = 2;
  localparam int LnVy2 = 3;
  localparam int LnUxv = 4;
  localparam int LnUyv = 5;
  localparam int LnDx2 = 6;
  localparam int LnDy2 = 7;

  function automatic logic [MagBits-1:0] mag_f(input logic signed [MagBits-1:0] d);
    mag_f = d[MagBits-1] ? MagBits'(-d) : MagBits'(d);
  endfunction

  // configuration registers
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [LIMIT_BITS-1:0]        near_q, far_q;

  // sequencer and vertex state
  ppsd_state_e                  state_q, state_d;
  logic                         first_q, hit_q, last_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic [LIMIT_BITS-1:0]        best_q;
  logic                         sgn1_q, sgn2_q;

  // sums and score
  logic [SumBits-1:0]           uu_q, vv_q, dd_q, score_q;
  logic signed [SumBits:0]      nd_q;

  // result register
  logic                         res_valid_q, res_hit_q;
  logic [LIMIT_BITS-1:0]        res_dist_q;

  // control
  logic in_acc, lane_start, sq_start, div_start;
  logic ld_sum, ld_first, ld_dd, ld_div, set_hit, upd_best, res_load, res_free;

  // combinational datapath
  logic signed [MagBits-1:0] ux_w, uy_w, vx_w, vy_w, dx_w, dy_w;
  logic [MagBits-1:0]        lane_a [Lanes];
  logic [MagBits-1:0]        lane_b [Lanes];
  logic [2*MagBits-1:0]      lane_p [Lanes];
  logic [Lanes-1:0]          lane_busy;
  logic signed [SumBits:0]   nd_t1, nd_t2;
  logic [SumBits-1:0]        s_w;
  logic                      nd_pos, better, near_hit;
  logic [2*SumBits-1:0]      sq_p;
  logic [SumBits-1:0]        div_q;
  logic                      sq_busy, div_busy;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q   <= '0;
      qy_q   <= '0;
      near_q <= '0;
      far_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (ppsd_cfg_e'(cfg_idx_i))
        CFG_QUERY_X:    qx_q   <= COORD_BITS'(cfg_wdata_i);
        CFG_QUERY_Y:    qy_q   <= COORD_BITS'(cfg_wdata_i);
        CFG_NEAR_LIMIT: near_q <= cfg_wdata_i;
        CFG_FAR_LIMIT:  far_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Differences and product lanes
  // --------------------------------------------------------------------------
  always_comb begin
    ux_w = MagBits'(prev_x_q) - MagBits'(qx_q);
    uy_w = MagBits'(prev_y_q) - MagBits'(qy_q);
    vx_w = MagBits'(vertex_i.vertex_x) - MagBits'(prev_x_q);
    vy_w = MagBits'(vertex_i.vertex_y) - MagBits'(prev_y_q);
    dx_w = MagBits'(vertex_i.vertex_x) - MagBits'(qx_q);
    dy_w = MagBits'(vertex_i.vertex_y) - MagBits'(qy_q);

    lane_a[LnUx2] = mag_f(ux_w);  lane_b[LnUx2] = mag_f(ux_w);
    lane_a[LnUy2] = mag_f(uy_w);  lane_b[LnUy2] = mag_f(uy_w);
    lane_a[LnVx2] = mag_f(vx_w);  lane_b[LnVx2] = mag_f(vx_w);
    lane_a[LnVy2] = mag_f(vy_w);  lane_b[LnVy2] = mag_f(vy_w);
    lane_a[LnUxv] = mag_f(ux_w);  lane_b[LnUxv] = mag_f(vx_w);
    lane_a[LnUyv] = mag_f(uy_w);  lane_b[LnUyv] = mag_f(vy_w);
    lane_a[LnDx2] = mag_f(dx_w);  lane_b[LnDx2] = mag_f(dx_w);
    lane_a[LnDy2] = mag_f(dy_w);  lane_b[LnDy2] = mag_f(dy_w);
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    ppsd_ser_mul #(.W(MagBits)) u_mul (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (lane_start),
      .a_i       (lane_a[g]),
      .b_i       (lane_b[g]),
      .busy_o    (lane_busy[g]),
      .product_o (lane_p[g])
    );
  end

  // s = -(u.v): a term with a positive dot sign counts negatively
  always_comb begin
    nd_t1 = $signed((SumBits+1)'(lane_p[LnUxv]));
    nd_t2 = $signed((SumBits+1)'(lane_p[LnUyv]));
    if (!sgn1_q) nd_t1 = -nd_t1;
    if (!sgn2_q) nd_t2 = -nd_t2;
    s_w      = nd_q[SumBits-1:0];
    nd_pos   = !nd_q[SumBits] && (nd_q != '0);
    better   = (CmpBits'(score_q) < CmpBits'(best_q));
    near_hit = (CmpBits'(score_q) <= CmpBits'(near_q));
  end

  // --------------------------------------------------------------------------
  // Foot point: s^2 then s^2 / |v|^2
  // --------------------------------------------------------------------------
  ppsd_ser_mul #(.W(SumBits)) u_square (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .a_i       (s_w),
    .b_i       (s_w),
    .busy_o    (sq_busy),
    .product_o (sq_p)
  );

  ppsd_ser_div #(.N(SumBits)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sq_p),
    .divisor_i  (vv_q),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_acc     = 1'b0;
    lane_start = 1'b0;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    ld_sum     = 1'b0;
    ld_first   = 1'b0;
    ld_dd      = 1'b0;
    ld_div     = 1'b0;
    set_hit    = 1'b0;
    upd_best   = 1'b0;
    res_load   = 1'b0;
    res_free   = !res_valid_q || result_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (vertex_i.valid) begin
          in_acc     = 1'b1;
          lane_start = 1'b1;
          state_d    = ST_PROD;
        end
      end
      ST_PROD: begin
        if (lane_busy == '0) state_d = ST_SUM;
      end
      ST_SUM: begin
        ld_sum  = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // first vertex seeds; a latched hit or an unscored segment is dropped
        if (first_q) begin
          ld_first = 1'b1;
          state_d  = ST_FINISH;
        end else if (hit_q || vv_q == '0 || !nd_pos) begin
          state_d = ST_FINISH;
        end else if (s_w >= vv_q) begin
          ld_dd   = 1'b1;
          state_d = ST_SCORE;
        end else begin
          sq_start = 1'b1;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (!sq_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!div_busy) begin
          ld_div  = 1'b1;
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        set_hit  = better && near_hit;
        upd_best = better && !near_hit;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        // hold a last vertex until the result register is free
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (res_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (ld_first) begin
        first_q <= 1'b0;
        hit_q   <= 1'b0;
      end
      if (set_hit) hit_q <= 1'b1;
      if (res_load) begin
        first_q <= 1'b1;
        hit_q   <= 1'b0;
      end
      if (res_load)            res_valid_q <= 1'b1;
      else if (result_o.ready) res_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_x_q <= vertex_i.vertex_x;
      prev_y_q <= vertex_i.vertex_y;
      last_q   <= vertex_i.last_vertex;
      sgn1_q   <= ux_w[MagBits-1] ^ vx_w[MagBits-1];
      sgn2_q   <= uy_w[MagBits-1] ^ vy_w[MagBits-1];
    end
    if (ld_sum) begin
      uu_q <= SumBits'(lane_p[LnUx2]) + SumBits'(lane_p[LnUy2]);
      vv_q <= SumBits'(lane_p[LnVx2]) + SumBits'(lane_p[LnVy2]);
      dd_q <= SumBits'(lane_p[LnDx2]) + SumBits'(lane_p[LnDy2]);
      nd_q <= nd_t1 + nd_t2;
    end
    if (ld_first) begin
      best_q <= (CmpBits'(dd_q) < CmpBits'(far_q)) ? LIMIT_BITS'(dd_q) : far_q;
    end
    if (ld_dd)    score_q <= dd_q;
    if (ld_div)   score_q <= uu_q - div_q;
    if (upd_best) best_q  <= LIMIT_BITS'(score_q);
    if (res_load) begin
      res_dist_q <= hit_q ? near_q : best_q;
      res_hit_q  <= hit_q;
    end
  end

  assign vertex_i.ready            = (state_q == ST_IDLE);
  assign result_o.valid            = res_valid_q;
  assign result_o.squared_distance = res_dist_q;
  assign result_o.close_hit        = res_hit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sq_only_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> (s_w < vv_q))
    else $error("foot point squared with s not below |v|^2");

  a_div_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (sq_p[2*SumBits-1:SumBits] < vv_q))
    else $error("quotient would overflow divider width");

  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_FINISH && last_q))
    else $error("result raised without a finished last vertex");

  a_hit_reports_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && hit_q) |=> (res_dist_q == $past(near_q)) && res_hit_q)
    else $error("close hit reported without the near limit");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_polyline_squared_distance_top
// Streams polylines into the vertex channel, predicts the squared distance of
// each polyline from the query point in a small scoreboard and checks every
// result item field by field. Both channels idle and stall at random, and the
// registers are rewritten between phases, mid-polyline too.
// ----------------------------------------------------------------------------
module tb;
  import ppsd_pkg::*;

  localparam int     COORD_BITS      = 24;
  localparam longint COORD_MAX       = 64'sd8388607;
  localparam longint COORD_MIN       = -64'sd8388608;
  localparam longint LIMIT_MAX       = (64'sd1 <<< LIMIT_BITS) - 1;
  localparam int     MAX_GAP         = 17;
  // Drain time covers a scored segment through to its result item, with margin.
  localparam int     DRAIN_CYCLES    = 120;
  localparam int     STALL_LIMIT     = 2000;
  localparam int     RANDOM_VERTICES = 1850;

  // --------------------------------------------------------------------------
  // Distance predictor and store of expected polyline results
  // --------------------------------------------------------------------------
  class polyline_distance_sb;
    typedef struct packed {
      logic [LIMIT_BITS-1:0] sq_dist;
      logic                  close;
    } distance_t;

    longint    query_x, query_y, near_limit, far_limit;
    longint    prev_x, prev_y, best_dist;
    bit        awaiting_first, hit_latched;
    distance_t expected_q[$];
    int        errors, vertices, polylines, hits, divisions;

    function new();
      query_x        = 0;
      query_y        = 0;
      near_limit     = 0;
      far_limit      = LIMIT_MAX;
      prev_x         = 0;
      prev_y         = 0;
      best_dist      = 0;
      awaiting_first = 1'b1;
      hit_latched    = 1'b0;
    endfunction

    function void set_reg(ppsd_cfg_e idx, logic [LIMIT_BITS-1:0] value);
      logic signed [COORD_BITS-1:0] coord;
      coord = value[COORD_BITS-1:0];
      case (idx)
        CFG_QUERY_X:    query_x    = coord;
        CFG_QUERY_Y:    query_y    = coord;
        CFG_NEAR_LIMIT: near_limit = value;
        CFG_FAR_LIMIT:  far_limit  = value;
        default: ;
      endcase
    endfunction

    function longint sq_len(longint dx, longint dy);
      return dx * dx + dy * dy;
    endfunction

    // floor(s^2 / seg_len): s^2 needs up to about 100 bits
    function longint foot_drop(longint s, longint seg_len);
      bit [127:0] num, den;
      num = s;
      num = num * num;
      den = seg_len;
      return longint'(num / den);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void absorb_vertex(logic signed [COORD_BITS-1:0] vx,
                                logic signed [COORD_BITS-1:0] vy, bit is_last);
      longint    x, y, ux, uy, dx, dy, seg_len, dot, s, score;
      distance_t want;
      x = vx;
      y = vy;
      vertices++;
      if (awaiting_first) begin
        score          = sq_len(x - query_x, y - query_y);
        best_dist      = (score < far_limit) ? score : far_limit;
        awaiting_first = 1'b0;
        hit_latched    = 1'b0;
      end else if (!hit_latched) begin
        ux      = prev_x - query_x;
        uy      = prev_y - query_y;
        dx      = x - prev_x;
        dy      = y - prev_y;
        seg_len = sq_len(dx, dy);
        dot     = ux * dx + uy * dy;
        if (seg_len != 0 && dot < 0) begin
          s = -dot;
          if (s >= seg_len) begin
            score = sq_len(x - query_x, y - query_y);
          end else begin
            score = sq_len(ux, uy) - foot_drop(s, seg_len);
            divisions++;
          end
          if (score < best_dist) begin
            if (score <= near_limit) hit_latched = 1'b1;
            else best_dist = score;
          end
        end
      end
      prev_x = x;
      prev_y = y;
      if (is_last) begin
        want.sq_dist = hit_latched ? near_limit[LIMIT_BITS-1:0] : best_dist[LIMIT_BITS-1:0];
        want.close   = hit_latched;
        expected_q   = {expected_q, want};
        polylines++;
        if (hit_latched) hits++;
        awaiting_first = 1'b1;
        hit_latched    = 1'b0;
      end
    endfunction

    function void check_result(logic [LIMIT_BITS-1:0] sq_dist, logic close);
      distance_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no polyline pending: squared_distance %0d close_hit %0b",
               sq_dist, close);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (sq_dist !== want.sq_dist) begin
        $error("squared_distance: expected %0d, got %0d", want.sq_dist, sq_dist);
        errors++;
      end
      if (close !== want.close) begin
        $error("close_hit: expected %0b, got %0b", want.close, close);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i   = '0;
  logic [LIMIT_BITS-1:0]   cfg_wdata_i = '0;

  ppsd_vertex_if #(.COORD_BITS(COORD_BITS)) vtx_if ();
  ppsd_result_if                            res_if ();

  polyline_distance_sb sb = new();

  bit gaps_on     = 1'b1;   // cleared for phases that run both sides flat out
  int reg_writes  = 0;
  int idle_cycles = 0;

  point_polyline_squared_distance_top #(
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vertex_i    (vtx_if),
    .result_o    (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, sb.pending());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one vertex after a random gap, hold it until taken, then predict.
  task automatic send_vertex(input longint x, input longint y, input bit is_last);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      vtx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vtx_if.valid       <= 1'b1;
    vtx_if.vertex_x    <= x[COORD_BITS-1:0];
    vtx_if.vertex_y    <= y[COORD_BITS-1:0];
    vtx_if.last_vertex <= is_last;
    do @(posedge clk_i); while (!vtx_if.ready);
    sb.absorb_vertex(x[COORD_BITS-1:0], y[COORD_BITS-1:0], is_last);
  endtask

  // One-cycle register write; coordinates go out sign-extended.
  task automatic write_reg(input ppsd_cfg_e idx, input longint value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[LIMIT_BITS-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, value[LIMIT_BITS-1:0]);
    reg_writes++;
  endtask

  // Drop the vertex offer, wait for every expected result, then let a vertex
  // still in flight finish.
  task automatic settle();
    @(negedge clk_i);
    vtx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic longint clip_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Coordinate within 2^span of the centre; full range now and then.
  function automatic longint pick_coord(longint centre, int span);
    logic signed [COORD_BITS-1:0] raw;
    longint                       half;
    if ($urandom_range(0, 31) == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    if (span >= COORD_BITS || $urandom_range(0, 15) == 0) begin
      raw = COORD_BITS'($urandom);
      return longint'(raw);
    end
    half = 64'sd1 <<< span;
    return clip_coord(centre - half + longint'($urandom_range(0, 32'(2 * half))));
  endfunction

  function automatic longint rand_bits(int bits);
    longint r;
    r = {$urandom, $urandom};
    return r & ((64'sd1 <<< bits) - 1);
  endfunction

  // Result side: stall for a random spell before each item, then take it.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall;
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      sb.check_result(res_if.squared_distance, res_if.close_hit);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int     sent, left_in_line, span, phase_len;
    logic [3:0] reg_mask;
    longint qx, qy, x, y, px, py;

    vtx_if.valid       = 1'b0;
    vtx_if.vertex_x    = '0;
    vtx_if.vertex_y    = '0;
    vtx_if.last_vertex = 1'b0;

    // Hold reset low, then release it on a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- Directed part -----------------------------------------------------
    // Reset values: query at the origin, near limit at zero, far limit wide open.
    // One-vertex polylines at both corners give the largest distances.
    send_vertex(COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);

    // Foot point inside the segment: needs the division.
    send_vertex(-100, 50, 1'b0);
    send_vertex(100, 50, 1'b1);
    // Projection beyond the end vertex: score is the end vertex distance.
    send_vertex(-100, 50, 1'b0);
    send_vertex(-50, 50, 1'b1);
    // Zero-length segment, a segment heading away, then one through the
    // origin; the score reaches the near limit of zero and counts as a hit.
    send_vertex(10, 10, 1'b0);
    send_vertex(10, 10, 1'b0);
    send_vertex(20, 20, 1'b0);
    send_vertex(-5, -5, 1'b1);

    // Hit mid-polyline: the vertices after it must be dropped.
    settle();
    write_reg(CFG_NEAR_LIMIT, 3000);
    send_vertex(-100, 50, 1'b0);
    send_vertex(100, 50, 1'b0);
    send_vertex(500, 500, 1'b0);
    send_vertex(0, 0, 1'b1);

    // Near limit above the far limit: the near limit is still reported.
    settle();
    write_reg(CFG_FAR_LIMIT, 4000);
    write_reg(CFG_NEAR_LIMIT, 6000);
    send_vertex(-100, 50, 1'b0);
    send_vertex(100, 50, 1'b1);

    // Both limits at zero: everything clamps to nothing.
    settle();
    write_reg(CFG_NEAR_LIMIT, 0);
    write_reg(CFG_FAR_LIMIT, 0);
    send_vertex(7, 7, 1'b1);

    // Query in a corner, segment ending on it from the opposite corner.
    settle();
    write_reg(CFG_FAR_LIMIT, LIMIT_MAX);
    write_reg(CFG_QUERY_X, COORD_MAX);
    write_reg(CFG_QUERY_Y, COORD_MIN);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);

    // Full-length diagonal, then move the query mid-polyline.
    settle();
    write_reg(CFG_QUERY_X, 0);
    write_reg(CFG_QUERY_Y, 0);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    settle();
    write_reg(CFG_QUERY_X, 1000);
    write_reg(CFG_QUERY_Y, -1000);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);

    // Near limit at its top: the first improvement is a hit.
    settle();
    write_reg(CFG_QUERY_X, 0);
    write_reg(CFG_QUERY_Y, 0);
    write_reg(CFG_NEAR_LIMIT, LIMIT_MAX);
    send_vertex(3, 4, 1'b0);
    send_vertex(-3, 4, 1'b1);

    // ---- Random part -------------------------------------------------------
    // Phases of fresh settings; each phase clusters its polylines around the
    // query at one scale so that scored segments and hits stay common. A phase
    // may end mid-polyline, so registers also change between vertices.
    sent         = 0;
    left_in_line = 0;
    px           = 0;
    py           = 0;
    reg_mask     = 4'hF;
    qx           = 0;
    qy           = 0;
    while (sent < RANDOM_VERTICES) begin
      settle();
      span = ($urandom_range(0, 4) == 0) ? COORD_BITS : $urandom_range(3, COORD_BITS - 1);
      if (reg_mask[0]) begin
        qx = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? COORD_MAX : COORD_MIN)
                                         : pick_coord(0, COORD_BITS);
        write_reg(CFG_QUERY_X, qx);
      end
      if (reg_mask[1]) begin
        qy = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? COORD_MAX : COORD_MIN)
                                         : pick_coord(0, COORD_BITS);
        write_reg(CFG_QUERY_Y, qy);
      end
      if (reg_mask[2]) begin
        case ($urandom_range(0, 9))
          0, 1:    write_reg(CFG_NEAR_LIMIT, 0);
          9:       write_reg(CFG_NEAR_LIMIT, LIMIT_MAX);
          default: write_reg(CFG_NEAR_LIMIT, rand_bits(2 * span - 1));
        endcase
      end
      if (reg_mask[3]) begin
        case ($urandom_range(0, 9))
          0:             write_reg(CFG_FAR_LIMIT, 0);
          1, 2, 3, 4:    write_reg(CFG_FAR_LIMIT, LIMIT_MAX);
          default:       write_reg(CFG_FAR_LIMIT, rand_bits(2 * span + 1));
        endcase
      end
      reg_mask  = 4'($urandom_range(1, 15));
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 90);
      repeat (phase_len) begin
        if (left_in_line == 0) begin
          left_in_line = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                                     : $urandom_range(2, 9);
        end
        // Repeat the previous vertex now and then for zero-length segments.
        if ($urandom_range(0, 15) == 0) begin
          x = px;
          y = py;
        end else begin
          x = pick_coord(qx, span);
          y = pick_coord(qy, span);
        end
        send_vertex(x, y, left_in_line == 1);
        px = x;
        py = y;
        left_in_line--;
        sent++;
      end
    end
    // Close any polyline left open by the last phase.
    if (left_in_line > 0) send_vertex(pick_coord(qx, span), pick_coord(qy, span), 1'b1);

    // ---- Wind down ---------------------------------------------------------
    @(negedge clk_i);
    vtx_if.valid <= 1'b0;
    settle();

    $display("Run covered %0d vertices in %0d polylines, %0d close hits, %0d divisions,",
             sb.vertices, sb.polylines, sb.hits, sb.divisions);
    $display("with %0d register writes across random phases of gaps and stalls.",
             reg_writes);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
